>>> sv/sst_pkg.sv
// Shared constants for the sum segment tree unit.
package sst_pkg;

  localparam int LEAVES_DEFAULT = 1024;
  localparam int VALUE_W        = 32;
  localparam int SUM_W          = 64;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

>>> sv/sum_segment_tree_unit.sv
// Sum segment tree: point add and half-open range sum over one node memory.
//
// Command channel: drive start with the in_ fields; the transfer happens on
// the rising edge where start is high and busy is low. in_func selects an
// add of in_value to leaf in_position, or a sum over [in_range_low,
// in_range_high), each bound clipped to LEAVES. Only queries give a result.
// Result channel: out_sum is valid for exactly one cycle while out_valid is
// high; the receiver cannot stall it. It rises in the same cycle that busy
// falls after a query.
// Operation: an add keeps busy high while it writes the leaf and then each
// parent up to the root, paced by the single read and write port pair of
// the node memory (sibling read and parent write share each cycle). A query
// walks the levels bottom up through S_Q_TOP, optionally S_Q_LOD, S_Q_HIC
// and optionally S_Q_HID until the bounds meet, ending with a final check
// in S_Q_TOP, paced by the one memory read port and its registered read.
// Reset: after rst_n is released a clearing pass writes zero to all
// 2*LEAVES node entries, one per cycle, and holds busy high throughout.
module sum_segment_tree_unit #(
  parameter int LEAVES = sst_pkg::LEAVES_DEFAULT,
  localparam int LW = $clog2(LEAVES)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_func,
  input  logic [LW-1:0]                    in_position,
  input  logic signed [sst_pkg::VALUE_W-1:0] in_value,
  input  logic [LW:0]                      in_range_low,
  input  logic [LW:0]                      in_range_high,
  output logic                             out_valid,
  output logic signed [sst_pkg::SUM_W-1:0] out_sum
);

  localparam int NW = LW + 1;          // node index width
  localparam int QW = LW + 2;          // query bound width, holds 2*LEAVES
  localparam int RW = LW + 1;          // range port width
  localparam int DEPTH = 2 * LEAVES;
  localparam int SW = sst_pkg::SUM_W;

  localparam logic [RW-1:0] LEAVES_R = RW'(LEAVES);
  localparam logic [QW-1:0] LEAVES_Q = QW'(LEAVES);
  localparam logic [NW-1:0] ROOT     = NW'(1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_U_LEAF, S_U_PAR, S_Q_TOP, S_Q_LOD, S_Q_HIC, S_Q_HID
  } state_t;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [SW-1:0]   acc_r, acc_nxt;
  logic [SW-1:0]   amount_r, amount_nxt;
  logic [QW-1:0]   lo_r, lo_nxt;
  logic [QW-1:0]   hi_r, hi_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   out_sum_r, out_sum_nxt;

  logic [SW-1:0]   mem [DEPTH];
  logic [SW-1:0]   mem_rdata_r;
  logic [NW-1:0]   mem_raddr;
  logic [NW-1:0]   mem_waddr;
  logic [SW-1:0]   mem_wdata;
  logic            mem_we;

  logic            accept;
  logic [RW-1:0]   lo_clip, hi_clip;
  logic [SW-1:0]   add_b, add_sum;
  logic [NW-1:0]   parent;
  logic [QW-1:0]   hi_dec;

  assign accept  = start && !busy;
  assign lo_clip = (in_range_low  > LEAVES_R) ? LEAVES_R : in_range_low;
  assign hi_clip = (in_range_high > LEAVES_R) ? LEAVES_R : in_range_high;
  assign add_b   = (state_r == S_U_LEAF) ? amount_r : acc_r;
  assign add_sum = mem_rdata_r + add_b;
  assign parent  = node_r >> 1;
  assign hi_dec  = hi_r - QW'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    acc_nxt       = acc_r;
    amount_nxt    = amount_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = add_sum;
    mem_raddr     = lo_r[NW-1:0];
    case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + NW'(1);
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        // issue the leaf read up front; harmless if no add is taken
        mem_raddr = {1'b1, in_position};
        if (accept) begin
          acc_nxt = '0;
          if (in_func == sst_pkg::FUNC_ADD) begin
            node_nxt   = {1'b1, in_position};
            amount_nxt = SW'(in_value);
            state_nxt  = S_U_LEAF;
          end else begin
            lo_nxt    = {1'b0, lo_clip} + LEAVES_Q;
            hi_nxt    = {1'b0, hi_clip} + LEAVES_Q;
            state_nxt = S_Q_TOP;
          end
        end
      end
      S_U_LEAF: begin
        // write the leaf, fetch its sibling
        mem_we    = 1'b1;
        mem_raddr = node_r ^ NW'(1);
        acc_nxt   = add_sum;
        state_nxt = S_U_PAR;
      end
      S_U_PAR: begin
        // parent = held child + sibling; fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_raddr = parent ^ NW'(1);
        acc_nxt   = add_sum;
        node_nxt  = parent;
        if (parent == ROOT) state_nxt = S_IDLE;
      end
      S_Q_TOP: begin
        if (lo_r < hi_r) begin
          state_nxt = lo_r[0] ? S_Q_LOD : S_Q_HIC;
        end else begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      S_Q_LOD: begin
        acc_nxt   = add_sum;
        lo_nxt    = lo_r + QW'(1);
        state_nxt = S_Q_HIC;
      end
      S_Q_HIC: begin
        mem_raddr = hi_dec[NW-1:0];
        if (hi_r[0]) begin
          hi_nxt    = hi_dec;
          state_nxt = S_Q_HID;
        end else begin
          lo_nxt    = lo_r >> 1;
          hi_nxt    = hi_r >> 1;
          state_nxt = S_Q_TOP;
        end
      end
      S_Q_HID: begin
        acc_nxt   = add_sum;
        lo_nxt    = lo_r >> 1;
        hi_nxt    = hi_r >> 1;
        state_nxt = S_Q_TOP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r    <= node_nxt;
    acc_r     <= acc_nxt;
    amount_r  <= amount_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    out_sum_r <= out_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

  // an update never reads the entry it writes in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLR) |-> (mem_waddr != mem_raddr))
    else $error("node read and write collide");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low after transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_LOD || state_r == S_Q_HIC || state_r == S_Q_HID)
      |-> (lo_r <= hi_r))
    else $error("query bounds crossed");

  a_update_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_U_PAR) |-> (node_r != '0))
    else $error("update walked past root");

endmodule

>>> tb/tb_sum_segment_tree_unit.sv
// Testbench for sum_segment_tree_unit: point adds and range sums checked against a leaf array.
`timescale 1ns / 100ps

module tb_sum_segment_tree_unit;

  localparam int LEAVES    = sst_pkg::LEAVES_DEFAULT;
  localparam int LW        = $clog2(LEAVES);
  localparam int VALUE_W   = sst_pkg::VALUE_W;
  localparam int SUM_W     = sst_pkg::SUM_W;
  localparam int RAND_CMDS = 750;
  localparam int DRAIN_MAX = 2000;
  localparam int SETTLE    = 4 * (LW + 1) + 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = sst_pkg::FUNC_ADD;
  logic [LW-1:0] in_position = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [LW:0] in_range_low = '0;
  logic [LW:0] in_range_high = '0;
  logic out_valid;
  logic signed [SUM_W-1:0] out_sum;

  // Leaf contents as the block should hold them, and sums still owed by it.
  logic signed [SUM_W-1:0] leaf_val [0:LEAVES-1];
  logic signed [SUM_W-1:0] pending_sums [$];

  int fail_count = 0;
  int sums_checked = 0;
  int adds_sent = 0;
  int queries_sent = 0;
  int clipped_queries = 0;
  int empty_queries = 0;
  bit burst_mode = 1'b0;

  sum_segment_tree_unit #(.LEAVES(LEAVES)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_sum       (out_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("sum_segment_tree_unit verification failed");
    $finish;
  end

  // Clip both bounds to the leaf count, then add up the half-open range.
  function automatic logic signed [SUM_W-1:0] leaf_range_sum(input logic [LW:0] lo,
                                                             input logic [LW:0] hi);
    int a;
    int b;
    logic signed [SUM_W-1:0] acc;
    a = (lo > LEAVES) ? LEAVES : int'(lo);
    b = (hi > LEAVES) ? LEAVES : int'(hi);
    acc = '0;
    for (int i = a; i < b; i++) acc = acc + leaf_val[i];
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(VALUE_W-1){1'b1}}};
      1: return {1'b1, {(VALUE_W-1){1'b0}}};
      2: return -1;
      3: return $signed(VALUE_W'($urandom_range(0, 15))) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Hold the command until the block takes it, then update the prediction.
  task automatic issue_cmd(input logic f, input logic [LW-1:0] pos,
                           input logic signed [VALUE_W-1:0] amt,
                           input logic [LW:0] lo, input logic [LW:0] hi);
    int gap;
    start         <= 1'b1;
    in_func       <= f;
    in_position   <= pos;
    in_value      <= amt;
    in_range_low  <= lo;
    in_range_high <= hi;
    do @(posedge clk); while (busy);
    if (f == sst_pkg::FUNC_ADD) begin
      leaf_val[pos] = leaf_val[pos] + amt;
      adds_sent++;
    end else begin
      pending_sums.insert(pending_sums.size(), leaf_range_sum(lo, hi));
      queries_sent++;
      if (lo > LEAVES || hi > LEAVES) clipped_queries++;
      if (lo >= hi || lo >= LEAVES) empty_queries++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_cmd(input logic [LW-1:0] pos, input logic signed [VALUE_W-1:0] amt);
    issue_cmd(sst_pkg::FUNC_ADD, pos, amt, (LW+1)'($urandom), (LW+1)'($urandom));
  endtask

  task automatic query_cmd(input logic [LW:0] lo, input logic [LW:0] hi);
    issue_cmd(sst_pkg::FUNC_QUERY, LW'($urandom), VALUE_W'($urandom), lo, hi);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sum %0d", $time, out_sum);
        fail_count++;
      end else begin
        if (out_sum !== pending_sums[0]) begin
          $display("%0t: sum mismatch, expected %0d, actual %0d",
                   $time, pending_sums[0], out_sum);
          fail_count++;
        end
        void'(pending_sums.pop_front());
        sums_checked++;
      end
    end
  end

  task automatic test_cleared_tree();
    query_cmd('0, (LW+1)'(LEAVES));
    query_cmd((LW+1)'(LEAVES - 1), (LW+1)'(LEAVES));
  endtask

  task automatic test_extreme_adds();
    add_cmd('0, {1'b0, {(VALUE_W-1){1'b1}}});
    add_cmd(LW'(LEAVES - 1), {1'b1, {(VALUE_W-1){1'b0}}});
    add_cmd(LW'(LEAVES / 2), -1);
    add_cmd('0, '0);
    add_cmd(LW'(1), 1);
    add_cmd(LW'(LEAVES - 2), {1'b1, {(VALUE_W-1){1'b0}}});
    query_cmd('0, (LW+1)'(LEAVES));
    query_cmd('0, (LW+1)'(1));
    query_cmd((LW+1)'(LEAVES - 1), (LW+1)'(LEAVES));
  endtask

  task automatic test_range_edges();
    query_cmd((LW+1)'(5), (LW+1)'(5));
    query_cmd((LW+1)'(LEAVES), '0);
    query_cmd((LW+1)'(LEAVES), {(LW+1){1'b1}});
    query_cmd('0, {(LW+1){1'b1}});
    query_cmd({(LW+1){1'b1}}, {(LW+1){1'b1}});
    query_cmd({(LW+1){1'b1}}, (LW+1)'(3));
    query_cmd((LW+1)'(LEAVES / 2 - 1), (LW+1)'(LEAVES / 2 + 1));
    query_cmd((LW+1)'(1), (LW+1)'(LEAVES - 1));
    query_cmd((LW+1)'(LEAVES - 2), (LW+1)'(LEAVES));
    query_cmd((LW+1)'(2), (LW+1)'(1));
  endtask

  task automatic test_random_mix();
    logic [LW-1:0] pos;
    logic [LW:0] lo;
    logic [LW:0] hi;
    int r;
    for (int i = 0; i < RAND_CMDS; i++) begin
      if (i % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        // concentrate some adds on a few leaves at either end
        r = $urandom_range(0, 9);
        if (r < 2) pos = LW'($urandom_range(0, 7));
        else if (r < 4) pos = LW'($urandom_range(LEAVES - 8, LEAVES - 1));
        else pos = LW'($urandom);
        add_cmd(pos, pick_amount());
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          lo = (LW+1)'($urandom_range(0, LEAVES));
          hi = (LW+1)'($urandom_range(int'(lo), LEAVES));
        end else if (r == 7) begin
          hi = (LW+1)'($urandom_range(0, LEAVES - 1));
          lo = (LW+1)'($urandom_range(int'(hi), LEAVES));
        end else if (r == 8) begin
          lo = (LW+1)'($urandom_range(0, 2 * LEAVES - 1));
          hi = (LW+1)'($urandom_range(LEAVES, 2 * LEAVES - 1));
        end else begin
          lo = (LW+1)'($urandom);
          hi = (LW+1)'($urandom);
        end
        query_cmd(lo, hi);
      end
    end
  endtask

  initial begin
    int waited;
    for (int i = 0; i < LEAVES; i++) leaf_val[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_cleared_tree();
    test_extreme_adds();
    test_range_edges();
    test_random_mix();
    @(posedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_sums.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_sums.size() != 0) begin
      $display("%0t: %0d sums never arrived, expected next %0d",
               $time, pending_sums.size(), pending_sums[0]);
      fail_count++;
    end
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d leaf adds and %0d range queries (%0d clipped, %0d empty).",
             adds_sent, queries_sent, clipped_queries, empty_queries);
    $display("Compared %0d returned sums, %0d mismatches or stray results.",
             sums_checked, fail_count);
    if (fail_count == 0) begin
      $display("sum_segment_tree_unit verification clean");
    end else begin
      $display("sum_segment_tree_unit verification failed");
    end
    $finish;
  end

endmodule
